/* design/utf8_stream_decoder_macros.svh */
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/utf8sd_pkg.sv */
// Types and constants shared by the UTF-8 stream decoder modules.
package utf8sd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP_LEN2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_LEN3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_LEN4 = 21'h010000;
  localparam logic [CP_W-1:0] REPL_RESET  = 21'h00FFFD;

  // Configuration register indexes.
  localparam logic REG_REPL_CODE  = 1'b0;
  localparam logic REG_UPPER_EN   = 1'b1;

  // The results caused by one byte: cnt results, all replacements except
  // that the final one is the decoded code point when tail_ok is set.
  typedef struct packed {
    logic [2:0]      cnt;
    logic            tail_ok;
    logic [CP_W-1:0] cp;
  } grp_t;

endpackage

/* design/utf8sd_decode.sv */
// Sequence state and byte decode for the UTF-8 stream decoder.
`include "utf8_stream_decoder_macros.svh"

module utf8sd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        byte_i,
  output utf8sd_pkg::grp_t  grp_o
);
  import utf8sd_pkg::*;

  logic [2:0]      el_q, el_d;
  logic [2:0]      br_q, br_d;
  logic [CP_W-1:0] pv_q, pv_d;
  logic [CP_W-1:0] pv_ext;
  logic [2:0]      br_inc;
  logic [2:0]      pre;
  logic            bad;

  assign pv_ext = {pv_q[CP_W-7:0], byte_i[5:0]};
  assign br_inc = br_q + 3'd1;

  always_comb begin
    bad = ((el_q == 3'd2) && (pv_ext < MIN_CP_LEN2)) ||
          ((el_q == 3'd3) && (pv_ext < MIN_CP_LEN3)) ||
          ((el_q == 3'd4) && (pv_ext < MIN_CP_LEN4)) ||
          ((pv_ext >= SURR_LO) && (pv_ext <= SURR_HI)) ||
          (pv_ext > MAX_CP);
  end

  always_comb begin
    el_d  = el_q;
    br_d  = br_q;
    pv_d  = pv_q;
    grp_o = '0;
    pre   = 3'd0;
    if ((el_q != 3'd0) && (byte_i[7:6] == 2'b10)) begin
      pv_d = pv_ext;
      br_d = br_inc;
      if (br_inc >= el_q) begin
        el_d = 3'd0;
        br_d = 3'd0;
        pv_d = '0;
        if (bad) begin
          grp_o.cnt = el_q;
        end else begin
          grp_o.cnt     = 3'd1;
          grp_o.tail_ok = 1'b1;
          grp_o.cp      = pv_ext;
        end
      end
    end else begin
      // A sequence cut short by a non-continuation byte gives one replacement.
      if (el_q != 3'd0) begin
        pre = 3'd1;
      end
      grp_o.cnt = pre;
      el_d      = 3'd0;
      br_d      = 3'd0;
      pv_d      = '0;
      if (byte_i == 8'h00) begin
        grp_o.cnt = pre;
      end else if (!byte_i[7]) begin
        grp_o.cnt     = pre + 3'd1;
        grp_o.tail_ok = 1'b1;
        grp_o.cp      = {{(CP_W-8){1'b0}}, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        el_d = 3'd2;
        br_d = 3'd1;
        pv_d = {{(CP_W-5){1'b0}}, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        el_d = 3'd3;
        br_d = 3'd1;
        pv_d = {{(CP_W-4){1'b0}}, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        el_d = 3'd4;
        br_d = 3'd1;
        pv_d = {{(CP_W-3){1'b0}}, byte_i[2:0]};
      end else begin
        grp_o.cnt = pre + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q <= 3'd0;
      br_q <= 3'd0;
      pv_q <= '0;
    end else if (adv_i) begin
      el_q <= el_d;
      br_q <= br_d;
      pv_q <= pv_d;
    end
  end

  `U8SD_ASSERT(a_len_legal,
    (el_q == 3'd0) || (el_q == 3'd2) || (el_q == 3'd3) || (el_q == 3'd4),
    "expected length out of range")
  `U8SD_ASSERT(a_cnt_below_len,
    (el_q != 3'd0) |-> ((br_q != 3'd0) && (br_q < el_q)),
    "received count not below expected length")
  `U8SD_ASSERT(a_idle_clear,
    (el_q == 3'd0) |-> ((br_q == 3'd0) && (pv_q == '0)),
    "sequence state not clear while nothing is pending")

endmodule

/* design/utf8sd_upper.sv */
// Optional upper-case map applied to a decoded code point.
module utf8sd_upper (
  input  logic                        en_i,
  input  utf8sd_pkg::grp_t            grp_i,
  output utf8sd_pkg::grp_t            grp_o
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] up;

  assign cp = grp_i.cp;

  always_comb begin
    if ((cp >= 21'h61) && (cp <= 21'h7A)) begin
      up = cp - 21'h20;
    end else if ((cp >= 21'hE0) && (cp <= 21'hFE) && (cp != 21'hF7)) begin
      up = cp - 21'h20;
    end else if (cp == 21'hFF) begin
      up = 21'h178;
    end else if (cp == 21'h131) begin
      up = 21'h49;
    end else if (cp == 21'h17F) begin
      up = 21'h53;
    end else if ((cp >= 21'h100) && (cp <= 21'h137)) begin
      up = cp[0] ? cp - 21'h1 : cp;
    end else if ((cp >= 21'h139) && (cp <= 21'h148)) begin
      up = cp[0] ? cp : cp - 21'h1;
    end else if ((cp >= 21'h14A) && (cp <= 21'h177)) begin
      up = cp[0] ? cp - 21'h1 : cp;
    end else if ((cp == 21'h17A) || (cp == 21'h17C) || (cp == 21'h17E)) begin
      up = cp - 21'h1;
    end else if (cp == 21'h1A1) begin
      up = 21'h1A0;
    end else if (cp == 21'h1B0) begin
      up = 21'h1AF;
    end else if (cp == 21'h3C2) begin
      up = 21'h3A3;
    end else if ((cp >= 21'h3B1) && (cp <= 21'h3C9)) begin
      up = cp - 21'h20;
    end else if ((cp >= 21'h430) && (cp <= 21'h44F)) begin
      up = cp - 21'h20;
    end else if ((cp >= 21'h450) && (cp <= 21'h45F)) begin
      up = cp - 21'h50;
    end else if ((cp >= 21'h1E00) && (cp <= 21'h1EFF)) begin
      up = cp[0] ? cp - 21'h1 : cp;
    end else begin
      up = cp;
    end
  end

  always_comb begin
    grp_o = grp_i;
    if (en_i && grp_i.tail_ok) begin
      grp_o.cp = up;
    end
  end

endmodule

/* design/utf8sd_out.sv */
// Result register that hands out the results of one byte, one per cycle while the output is not stalled.
`include "utf8_stream_decoder_macros.svh"

module utf8sd_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  utf8sd_pkg::grp_t            grp_i,
  input  logic [utf8sd_pkg::CP_W-1:0] repl_code_i,
  input  logic                        out_stall_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  output logic [utf8sd_pkg::CP_W-1:0] code_point_o,
  output logic                        was_replaced_o,
  output logic                        last_of_run_o
);
  import utf8sd_pkg::*;

  logic            valid_q, valid_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            tail_q;
  logic [CP_W-1:0] cp_q;
  logic            pop;
  logic            last;
  logic            is_tail;

  assign pop     = valid_q && !out_stall_i;
  assign last    = (cnt_q == 3'd1);
  assign free_o  = !valid_q || (pop && last);
  assign is_tail = last && tail_q;

  assign out_valid_o    = valid_q;
  assign code_point_o   = is_tail ? cp_q : repl_code_i;
  assign was_replaced_o = !is_tail;
  assign last_of_run_o  = last;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = grp_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
      if (last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tail_q <= grp_i.tail_ok;
      cp_q   <= grp_i.cp;
    end
  end

  `U8SD_ASSERT(a_cnt_range, valid_q |-> ((cnt_q != 3'd0) && (cnt_q <= 3'd4)), "result count out of range while valid")
  `U8SD_ASSERT(a_tail_short, (valid_q && tail_q) |-> (cnt_q <= 3'd2), "decoded point behind more than one replacement")
  `U8SD_ASSERT(a_drain, (pop && last && !load_i) |=> !valid_q, "result register not empty after its last result")

endmodule

/* design/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: byte in, code points out.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_stall_o   data_byte_i
//   out       output     out_valid_o/out_stall_i code_point_o, was_replaced_o, last_of_run_o
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// An item is accepted into the input register and decoded from there, and its
// results go to the result register once that is free; a byte can be taken
// every cycle while nothing backs up. A byte that causes k results holds the
// result register until all k are taken (k is at most four, for a rejected
// four-byte sequence), so the input waits while those results drain.
// Bytes that cause no result (lead bytes, the zero byte with nothing pending,
// continuation bytes mid-sequence) pass without using the result register.
// Reset clears the sequence state and both registers, restores the
// replacement code to FFFD and turns the upper-case map off.
// The input register waits while the result register is still busy, so a
// stall on the output backs up to in_stall_o within the same cycle.
module utf8_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [utf8sd_pkg::CP_W-1:0] code_point_o,
  output logic                        was_replaced_o,
  output logic                        last_of_run_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [utf8sd_pkg::CP_W-1:0] cfg_data_i
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0] repl_q;
  logic            upper_q;

  logic            a_valid_q, a_valid_d;
  logic [7:0]      a_byte_q;
  logic            a_adv;
  logic            in_acc;
  logic            out_free;

  grp_t            grp_raw;
  grp_t            grp_map;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q  <= REPL_RESET;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REPL_CODE: repl_q  <= cfg_data_i;
        REG_UPPER_EN:  upper_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // The held byte moves on when it has no result or the result register
  // frees up in this cycle.
  assign a_adv      = a_valid_q && ((grp_map.cnt == 3'd0) || out_free);
  assign in_stall_o = a_valid_q && !a_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_byte_q <= data_byte_i;
    end
  end

  utf8sd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (a_adv),
    .byte_i (a_byte_q),
    .grp_o  (grp_raw)
  );

  utf8sd_upper u_upper (
    .en_i  (upper_q),
    .grp_i (grp_raw),
    .grp_o (grp_map)
  );

  utf8sd_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (a_adv && (grp_map.cnt != 3'd0)),
    .grp_i          (grp_map),
    .repl_code_i    (repl_q),
    .out_stall_i    (out_stall_i),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .code_point_o   (code_point_o),
    .was_replaced_o (was_replaced_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

/* verif/utf8_stream_decoder_test.sv */
// Self-checking testbench for the UTF-8 stream decoder, random and directed byte streams.
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
  import utf8sd_pkg::*;

  // One result of the decoder as the checker expects it.
  typedef struct {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            run_end;
  } decoded_cp_t;

  typedef logic [7:0] byte_q_t[$];

  // The receiver holds off this long once, so that the decoder fills up.
  localparam int unsigned HOLD_CYCLES    = 200;
  // No handshake for this many cycles means the decoder is stuck.
  localparam int unsigned WATCHDOG_LIMIT = 1500;
  // A byte passes through the input register and then the result register;
  // this leaves some margin for bytes that cause no result.
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Tracks the decoder's sequence state and configuration on the
  // testbench side, turns each accepted byte into the code points it must
  // cause, and compares every code point that comes out against them.
  class decoded_cp_board;
    logic [2:0]      pend_len;
    logic [2:0]      pend_count;
    logic [CP_W-1:0] pend_bits;
    logic [CP_W-1:0] repl_code;
    logic            upper_en;
    decoded_cp_t     expected_cps[$];
    int unsigned     errors;

    function new();
      pend_len   = '0;
      pend_count = '0;
      pend_bits  = '0;
      repl_code  = REPL_RESET;
      upper_en   = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [CP_W-1:0] value);
      case (idx)
        REG_REPL_CODE: repl_code = value;
        REG_UPPER_EN:  upper_en  = value[0];
        default:       ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_cps.size();
    endfunction

    // Upper-case map for ASCII, Latin-1, Latin Extended-A, the two horned
    // Vietnamese vowels, Greek, Cyrillic and Latin Extended Additional.
    function logic [CP_W-1:0] upper_of(logic [CP_W-1:0] c);
      if (c >= 21'h61 && c <= 21'h7A) return c - 21'h20;
      if (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7) return c - 21'h20;
      if (c == 21'hFF) return 21'h178;
      if (c == 21'h131) return 21'h49;
      if (c == 21'h17F) return 21'h53;
      if (c >= 21'h100 && c <= 21'h137) return c[0] ? c - 21'h1 : c;
      if (c >= 21'h139 && c <= 21'h148) return c[0] ? c : c - 21'h1;
      if (c >= 21'h14A && c <= 21'h177) return c[0] ? c - 21'h1 : c;
      if (c == 21'h17A || c == 21'h17C || c == 21'h17E) return c - 21'h1;
      if (c == 21'h1A1) return 21'h1A0;
      if (c == 21'h1B0) return 21'h1AF;
      if (c == 21'h3C2) return 21'h3A3;
      if (c >= 21'h3B1 && c <= 21'h3C9) return c - 21'h20;
      if (c >= 21'h430 && c <= 21'h44F) return c - 21'h20;
      if (c >= 21'h450 && c <= 21'h45F) return c - 21'h50;
      if (c >= 21'h1E00 && c <= 21'h1EFF) return c[0] ? c - 21'h1 : c;
      return c;
    endfunction

    function decoded_cp_t decoded(logic [CP_W-1:0] c);
      decoded_cp_t r;
      r.code_point = upper_en ? upper_of(c) : c;
      r.replaced   = 1'b0;
      r.run_end    = 1'b0;
      return r;
    endfunction

    function decoded_cp_t replacement();
      decoded_cp_t r;
      r.code_point = repl_code;
      r.replaced   = 1'b1;
      r.run_end    = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      decoded_cp_t     run[$];
      logic [CP_W-1:0] c;
      logic            bad;
      if (pend_len != 0 && b[7:6] == 2'b10) begin
        // Continuation byte of the sequence under way.
        pend_bits  = {pend_bits[CP_W-7:0], b[5:0]};
        pend_count = pend_count + 3'd1;
        if (pend_count >= pend_len) begin
          c   = pend_bits;
          bad = (pend_len == 3'd2 && c < MIN_CP_LEN2) ||
                (pend_len == 3'd3 && c < MIN_CP_LEN3) ||
                (pend_len == 3'd4 && c < MIN_CP_LEN4) ||
                (c >= SURR_LO && c <= SURR_HI) || c > MAX_CP;
          // A rejected sequence stands for one replacement per byte.
          if (bad) repeat (pend_len) run.push_back(replacement());
          else run.push_back(decoded(c));
          pend_len   = '0;
          pend_count = '0;
          pend_bits  = '0;
        end
      end else begin
        // A sequence cut short by any other byte gives one replacement,
        // and that byte then starts over as a lead byte.
        if (pend_len != 0) begin
          run.push_back(replacement());
          pend_len   = '0;
          pend_count = '0;
          pend_bits  = '0;
        end
        if (b == 8'h00) begin
          // End of text: nothing to emit.
        end else if (b[7] == 1'b0) begin
          run.push_back(decoded({13'b0, b}));
        end else if (b[7:5] == 3'b110) begin
          pend_len = 3'd2; pend_count = 3'd1; pend_bits = {16'b0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          pend_len = 3'd3; pend_count = 3'd1; pend_bits = {17'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          pend_len = 3'd4; pend_count = 3'd1; pend_bits = {18'b0, b[2:0]};
        end else begin
          run.push_back(replacement());
        end
      end
      if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
      foreach (run[i]) expected_cps.push_back(run[i]);
    endfunction

    function void check_code_point(logic [CP_W-1:0] c, logic repl, logic run_end);
      decoded_cp_t want;
      if (expected_cps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result code_point=%h was_replaced=%b last_of_run=%b",
                 $time, c, repl, run_end);
        return;
      end
      want = expected_cps.pop_front();
      if (c !== want.code_point) begin
        errors++;
        $display("%0t: code_point expected %h actual %h", $time, want.code_point, c);
      end
      if (repl !== want.replaced) begin
        errors++;
        $display("%0t: was_replaced expected %b actual %b", $time, want.replaced, repl);
      end
      if (run_end !== want.run_end) begin
        errors++;
        $display("%0t: last_of_run expected %b actual %b", $time, want.run_end, run_end);
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [7:0]      data_byte_i = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [CP_W-1:0] code_point_o;
  logic            was_replaced_o;
  logic            last_of_run_o;
  logic            cfg_we_i    = 1'b0;
  logic            cfg_idx_i   = REG_REPL_CODE;
  logic [CP_W-1:0] cfg_data_i  = '0;

  // Idling switches per phase, and the one-shot request for a long
  // hold-off on the output side.
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_pending = 1'b0;

  decoded_cp_board cp_board = new();

  utf8_stream_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .was_replaced_o (was_replaced_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Both handshakes are sampled at the rising edge. All drivers update
  // through nonblocking assignments, so the values read here are those that
  // held just before the edge, which is what the decoder itself sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) cp_board.note_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        cp_board.check_code_point(code_point_o, was_replaced_o, last_of_run_o);
      end
    end
  end

  // The watchdog restarts its count at every handshake on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: before each item it stays stalled for a random number of
  // cycles, then takes the next item. The stall is only raised again after
  // the item has been taken, so it is never lowered and raised in one step.
  initial begin : receiver
    int unsigned hold;
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (hold_pending) begin
        hold         = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  // Offers one byte after a random gap and returns at the edge where the
  // decoder takes it. With no gap, valid simply stays high for the next byte.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input byte_q_t text);
    foreach (text[i]) send_byte(text[i]);
  endtask

  // Waits until every expected code point has come out, then gives bytes
  // that cause no result time to leave the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cp_board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written while the decoder is idle. The enable drops
  // for one cycle after each write, so back-to-back writes stay separate.
  task automatic write_reg(input logic idx, input logic [CP_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cp_board.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Appends the UTF-8 form of c with the given length. The length is not
  // checked against c, which is how overlong and out-of-range forms are made.
  function automatic void encode_utf8(ref byte_q_t q, input logic [CP_W-1:0] c,
                                      input int unsigned len);
    case (len)
      1: q.push_back({1'b0, c[6:0]});
      2: begin
        q.push_back({3'b110, c[10:6]});
        q.push_back({2'b10, c[5:0]});
      end
      3: begin
        q.push_back({4'b1110, c[15:12]});
        q.push_back({2'b10, c[11:6]});
        q.push_back({2'b10, c[5:0]});
      end
      default: begin
        q.push_back({5'b11110, c[20:18]});
        q.push_back({2'b10, c[17:12]});
        q.push_back({2'b10, c[11:6]});
        q.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed text, since only that walks through the full
  // multi-byte paths; the rest is end-of-text bytes, rejected sequences,
  // truncated sequences and raw noise.
  task automatic send_random_text(input int unsigned count);
    int unsigned     sent;
    int unsigned     kind;
    int unsigned     len;
    logic [CP_W-1:0] c;
    byte_q_t         q;
    sent = 0;
    while (sent < count) begin
      q    = {};
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 4))
          0: encode_utf8(q, CP_W'($urandom_range(1, 'h7F)), 1);
          // Weighted toward the Latin, Greek and Cyrillic letters.
          1: encode_utf8(q, CP_W'($urandom_range('h80, $urandom_range(0, 1) ? 'h4FF : 'h7FF)),
                         2);
          2: begin
            c = $urandom_range(0, 1) ? CP_W'($urandom_range('h800, 'hD7FF))
                                     : CP_W'($urandom_range('hE000, 'hFFFF));
            encode_utf8(q, c, 3);
          end
          3: encode_utf8(q, CP_W'($urandom_range('h1E00, 'h1EFF)), 3);
          default: encode_utf8(q, CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
        endcase
      end else if (kind < 62) begin
        q.push_back(8'h00);
      end else if (kind < 80) begin
        case ($urandom_range(0, 3))
          0: begin
            len = $urandom_range(2, 4);
            c   = CP_W'($urandom_range(0, len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
            encode_utf8(q, c, len);
          end
          1: encode_utf8(q, CP_W'($urandom_range('hD800, 'hDFFF)), 3);
          2: encode_utf8(q, CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
          default: begin
            // Cut short; whatever follows interrupts the sequence.
            len = $urandom_range(2, 4);
            c   = len == 2 ? CP_W'($urandom_range('h80, 'h7FF))
                : (len == 3 ? CP_W'($urandom_range('h800, 'hD7FF))
                            : CP_W'($urandom_range('h10000, 'h10FFFF)));
            encode_utf8(q, c, len);
            repeat ($urandom_range(1, len - 1)) void'(q.pop_back());
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
      end
      send_text(q);
      sent += q.size();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: plain ASCII, one sequence of each length, a stray
    // continuation, an invalid lead, an interrupted sequence, an overlong
    // form, a surrogate, a code point above the Unicode range, a partial
    // sequence flushed by the end of text, and a lone end of text.
    send_text({8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
               8'h80, 8'hFF, 8'hC3, 8'h41, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80,
               8'hF4, 8'h90, 8'h80, 8'h80, 8'hE2, 8'h82, 8'h00, 8'h00});
    settle();

    // Upper case on, replacement code at its lowest. The sender runs at full
    // rate while the receiver holds off once for a long stretch.
    write_reg(REG_REPL_CODE, '0);
    write_reg(REG_UPPER_EN, CP_W'(1));
    send_text({8'h61, 8'hC3, 8'hBF, 8'hE1, 8'hB8, 8'h81, 8'hD1, 8'h90, 8'hC3, 8'hB7,
               8'hF8});
    tx_idle_on   = 1'b0;
    hold_pending = 1'b1;
    send_random_text(60);
    settle();

    // Replacement code with every bit set, both sides at full speed.
    write_reg(REG_REPL_CODE, {CP_W{1'b1}});
    rx_idle_on = 1'b0;
    send_random_text(60);
    settle();

    // Highest valid code point as replacement, upper case off, idling again.
    write_reg(REG_REPL_CODE, MAX_CP);
    write_reg(REG_UPPER_EN, '0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random_text(60);
    settle();

    write_reg(REG_REPL_CODE, CP_W'($urandom_range(1, 'h10FFFE)));
    write_reg(REG_UPPER_EN, CP_W'(1));
    send_random_text(60);
    settle();

    if (cp_board.errors == 0 && cp_board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
